>>> hdl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants for the spatial tile cache with farthest eviction.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned CoordW = 26;
  localparam int unsigned WidthW = 16;
  localparam int unsigned OutIdxW = 4;
  localparam int unsigned QuotW  = 26;
  localparam int unsigned ScoreW = 28;
  localparam logic [WidthW-1:0] TileWidthReset = 16'd500;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POINT,
    ST_DIV,
    ST_BOUND,
    ST_SCAN,
    ST_SCORE,
    ST_FILL,
    ST_RESULT
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_pos;    // capture viewer position, reset neighbour counters
    logic make_point;  // form neighbour point from counters
    logic div_start;   // start the divider
    logic make_bounds; // turn quotients into tile bounds
    logic scan_start;  // clear scan pointer and hit/empty flags
    logic scan_step;   // inspect one slot
    logic score_start; // clear best score
    logic score_step;  // score one slot
    logic fill;        // write bounds into the chosen slot
    logic out_load;    // load the output register
    logic next_point;  // advance neighbour counters
  } stc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic scan_end;
    logic found_hit;
    logic found_empty;
    logic score_end;
    logic last_point;
  } stc_sts_t;

endpackage

>>> hdl/stc_divider.sv
// ----------------------------------------------------------------------------
// stc_divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module stc_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [stc_pkg::CoordW-1:0]    dividend_i,
  input  logic [stc_pkg::WidthW-1:0]           divisor_i,
  output logic                                 done_o,
  output logic signed [stc_pkg::QuotW-1:0]     quot_o
);
  import stc_pkg::*;

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic [CoordW-1:0] mag_q, mag_d;
  logic [WidthW:0]   rem_q, rem_d;
  logic [WidthW-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [WidthW:0]   trial;
  logic [WidthW:0]   shifted;

  always_comb begin
    shifted = {rem_q[WidthW-1:0], mag_q[CoordW-1]};
    trial   = shifted - {1'b0, dvs_q};
    mag_d   = mag_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      neg_d  = dividend_i[CoordW-1];
      mag_d  = dividend_i[CoordW-1] ? CoordW'(-dividend_i) : CoordW'(dividend_i);
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? WidthW'(1) : divisor_i;
      cnt_d  = CntW'(CoordW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[WidthW]) begin
        rem_d = trial;
        mag_d = {mag_q[CoordW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        mag_d = {mag_q[CoordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quot_o = neg_q ? QuotW'(-$signed(mag_q)) : QuotW'($signed(mag_q));

endmodule

>>> hdl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: nine points, each divide, scan; on a miss optional score, fill.
// ----------------------------------------------------------------------------
module stc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_busy_i,
  input  stc_pkg::stc_sts_t sts_i,
  output stc_pkg::stc_cmd_t cmd_o,
  output logic              idle_o
);
  import stc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        started_q, started_d;

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_POINT;
      ST_POINT:  begin
        state_d   = ST_DIV;
        started_d = 1'b0;
      end
      ST_DIV:    begin
        started_d = 1'b1;
        if (started_q && sts_i.div_done) state_d = ST_BOUND;
      end
      ST_BOUND:  state_d = ST_SCAN;
      ST_SCAN:   begin
        if (sts_i.found_hit) state_d = ST_RESULT;
        else if (sts_i.scan_end) state_d = sts_i.found_empty ? ST_FILL : ST_SCORE;
      end
      ST_SCORE:  if (sts_i.score_end) state_d = ST_FILL;
      ST_FILL:   state_d = ST_RESULT;
      ST_RESULT: if (!out_busy_i) state_d = sts_i.last_point ? ST_IDLE : ST_POINT;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    idle_o     = 1'b0;
    unique case (state_q)
      ST_IDLE:   begin
        in_stall_o    = 1'b0;
        idle_o        = 1'b1;
        cmd_o.load_pos = in_valid_i;
      end
      ST_POINT:  cmd_o.make_point = 1'b1;
      ST_DIV:    cmd_o.div_start = !started_q;
      ST_BOUND:  begin
        cmd_o.make_bounds = 1'b1;
        cmd_o.scan_start  = 1'b1;
      end
      ST_SCAN:   begin
        cmd_o.scan_step   = !sts_i.found_hit && !sts_i.scan_end;
        cmd_o.score_start = 1'b1;
      end
      ST_SCORE:  cmd_o.score_step = !sts_i.score_end;
      ST_FILL:   cmd_o.fill = 1'b1;
      ST_RESULT: begin
        cmd_o.out_load   = !out_busy_i;
        cmd_o.next_point = !out_busy_i;
      end
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_fill_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fill |=> !cmd_o.fill)
    else $error("double fill");
  a_scan_leads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCORE) |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_SCORE))
    else $error("score without scan");

endmodule

>>> hdl/stc_datapath.sv
// ----------------------------------------------------------------------------
// stc_datapath
// Neighbour point generation, tile bounds, slot store, serial scan and score.
// ----------------------------------------------------------------------------
module stc_datapath #(
  parameter int unsigned CacheSlots   = 16,
  parameter int unsigned NeighborSpan = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stc_pkg::stc_cmd_t                   cmd_i,
  output stc_pkg::stc_sts_t                   sts_o,
  input  logic signed [stc_pkg::PosW-1:0]     pos_x_i,
  input  logic signed [stc_pkg::PosW-1:0]     pos_y_i,
  input  logic [stc_pkg::WidthW-1:0]          tile_width_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stc_pkg::OutIdxW-1:0]         neighbor_o,
  output logic [stc_pkg::OutIdxW-1:0]         slot_o,
  output logic                                hit_o,
  output logic                                evicted_o,
  output logic signed [stc_pkg::CoordW-1:0]   tile_min_x_o,
  output logic signed [stc_pkg::CoordW-1:0]   tile_min_y_o,
  output logic                                last_o
);
  import stc_pkg::*;

  localparam int unsigned SlotW = (CacheSlots > 1) ? $clog2(CacheSlots) : 1;
  localparam int unsigned ScanW = $clog2(CacheSlots + 1);
  localparam int unsigned SpanW = (NeighborSpan > 1) ? $clog2(NeighborSpan) : 1;
  localparam int unsigned Half  = NeighborSpan / 2;
  localparam int unsigned EntW  = 4 * CoordW;
  localparam int unsigned NPts  = NeighborSpan * NeighborSpan;
  localparam int unsigned NIdxW = (NPts > 16) ? $clog2(NPts) : OutIdxW;

  logic signed [PosW-1:0]   px_q, py_q;
  logic [SpanW-1:0]         row_q, col_q;
  logic [NIdxW-1:0]         nidx_q;
  logic signed [CoordW-1:0] x_q, y_q;
  logic [WidthW-1:0]        w_eff;
  logic signed [CoordW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic                     divx_done, divy_done;
  logic signed [QuotW-1:0]  qx, qy;

  // store
  logic [CacheSlots-1:0]    valid_q;
  logic [SlotW-1:0]         rd_addr;
  logic [EntW-1:0]          rd_data, wr_data;
  logic [ScanW-1:0]         scan_q;
  logic                     rd_live_q;
  logic [SlotW-1:0]         rd_idx_q;
  logic                     hit_q, empty_q;
  logic [SlotW-1:0]         hit_idx_q, empty_idx_q, best_idx_q;
  logic [ScoreW-1:0]        best_q;
  logic                     evict_q;
  logic [SlotW-1:0]         tgt;

  assign w_eff = (tile_width_i == '0) ? WidthW'(1) : tile_width_i;

  // neighbour point: offset (k - Half) * w, small multiply
  logic signed [SpanW+1:0]  dc, dr;
  logic signed [CoordW-1:0] offx, offy;
  assign dc   = $signed({2'b00, col_q}) - $signed((SpanW+2)'(Half));
  assign dr   = $signed({2'b00, row_q}) - $signed((SpanW+2)'(Half));
  assign offx = CoordW'(dc) * $signed({1'b0, w_eff});
  assign offy = CoordW'(dr) * $signed({1'b0, w_eff});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pos) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
    if (cmd_i.make_point) begin
      x_q <= CoordW'(px_q) + offx;
      y_q <= CoordW'(py_q) + offy;
    end
    if (cmd_i.make_bounds) begin
      if (x_q[CoordW-1]) begin
        hix_q <= CoordW'(qx * $signed({1'b0, w_eff}));
        lox_q <= CoordW'((qx - 1) * $signed({1'b0, w_eff}));
      end else begin
        lox_q <= CoordW'(qx * $signed({1'b0, w_eff}));
        hix_q <= CoordW'((qx + 1) * $signed({1'b0, w_eff}));
      end
      if (y_q[CoordW-1]) begin
        hiy_q <= CoordW'(qy * $signed({1'b0, w_eff}));
        loy_q <= CoordW'((qy - 1) * $signed({1'b0, w_eff}));
      end else begin
        loy_q <= CoordW'(qy * $signed({1'b0, w_eff}));
        hiy_q <= CoordW'((qy + 1) * $signed({1'b0, w_eff}));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      nidx_q <= '0;
    end else if (cmd_i.load_pos) begin
      row_q  <= '0;
      col_q  <= '0;
      nidx_q <= '0;
    end else if (cmd_i.next_point) begin
      nidx_q <= nidx_q + 1'b1;
      if (col_q == SpanW'(NeighborSpan - 1)) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  stc_divider u_divx (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(x_q),
    .divisor_i(w_eff), .done_o(divx_done), .quot_o(qx)
  );
  stc_divider u_divy (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(y_q),
    .divisor_i(w_eff), .done_o(divy_done), .quot_o(qy)
  );

  // slot bounds memory; read data for a slot arrives in the cycle after the scan pointer addresses it
  assign rd_addr = SlotW'(scan_q);
  assign wr_data = {lox_q, hix_q, loy_q, hiy_q};
  assign tgt     = empty_q ? empty_idx_q : best_idx_q;

  stc_ram #(.Width(EntW), .Depth(CacheSlots)) u_ram (
    .clk_i,
    .we_i   (cmd_i.fill),
    .waddr_i(tgt),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  logic signed [CoordW-1:0] r_lox, r_hix, r_loy, r_hiy;
  assign {r_lox, r_hix, r_loy, r_hiy} = rd_data;

  logic inside_pt;
  assign inside_pt = (r_lox <= x_q) && (r_hix >= x_q) && (r_loy <= y_q) && (r_hiy >= y_q);

  logic signed [CoordW+2:0] cdx, cdy;
  logic [CoordW+2:0]        adx, ady;
  logic [CoordW+3:0]        ssum;
  logic [ScoreW-1:0]        score;
  assign cdx   = (CoordW+3)'(r_lox) + (CoordW+3)'(r_hix) - ((CoordW+3)'(x_q) <<< 1);
  assign cdy   = (CoordW+3)'(r_loy) + (CoordW+3)'(r_hiy) - ((CoordW+3)'(y_q) <<< 1);
  assign adx   = cdx[CoordW+2] ? (CoordW+3)'(-cdx) : (CoordW+3)'(cdx);
  assign ady   = cdy[CoordW+2] ? (CoordW+3)'(-cdy) : (CoordW+3)'(cdy);
  assign ssum  = (CoordW+4)'(adx) + (CoordW+4)'(ady);
  assign score = ScoreW'(ssum >> 1);

  logic stepping;
  assign stepping = cmd_i.scan_step || cmd_i.score_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      scan_q      <= '0;
      rd_live_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      evict_q     <= 1'b0;
      hit_idx_q   <= '0;
      empty_idx_q <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_q    <= '0;
        rd_live_q <= 1'b0;
        hit_q     <= 1'b0;
        empty_q   <= 1'b0;
        evict_q   <= 1'b0;
      end else if (cmd_i.score_start && !stepping) begin
        scan_q    <= '0;
        rd_live_q <= 1'b0;
        best_q    <= '0;
        best_idx_q <= '0;
      end else if (stepping) begin
        // issue read for scan_q, evaluate the slot read last cycle
        if (scan_q != ScanW'(CacheSlots)) scan_q <= scan_q + 1'b1;
        rd_live_q <= (scan_q != ScanW'(CacheSlots));
        rd_idx_q  <= rd_addr;
        if (rd_live_q) begin
          if (cmd_i.scan_step) begin
            if (valid_q[rd_idx_q]) begin
              if (inside_pt) begin
                hit_q     <= 1'b1;
                hit_idx_q <= rd_idx_q;
              end
            end else if (!empty_q) begin
              empty_q     <= 1'b1;
              empty_idx_q <= rd_idx_q;
            end
          end else if (score > best_q) begin
            best_q     <= score;
            best_idx_q <= rd_idx_q;
          end
        end
      end
      if (cmd_i.fill) begin
        valid_q[tgt] <= 1'b1;
        evict_q      <= !empty_q;
      end
    end
  end

  assign sts_o.div_done    = divx_done && divy_done;
  assign sts_o.found_hit   = hit_q;
  assign sts_o.found_empty = empty_q;
  assign sts_o.scan_end    = !rd_live_q && (scan_q == ScanW'(CacheSlots));
  assign sts_o.score_end   = !rd_live_q && (scan_q == ScanW'(CacheSlots));
  assign sts_o.last_point  = (nidx_q == NIdxW'(NPts - 1));

  // result register; tile_min taken from the bounds register on a fill and
  // from the hit slot on a hit (captured from the RAM read data in the scan)
  logic [SlotW-1:0] res_slot;
  assign res_slot = hit_q ? hit_idx_q : tgt;

  logic signed [CoordW-1:0] hmin_x_q, hmin_y_q;
  always_ff @(posedge clk_i) begin
    if (stepping && rd_live_q && cmd_i.scan_step && valid_q[rd_idx_q] && inside_pt && !hit_q) begin
      hmin_x_q <= r_lox;
      hmin_y_q <= r_loy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      neighbor_o   <= OutIdxW'(nidx_q);
      slot_o       <= OutIdxW'(res_slot);
      hit_o        <= hit_q;
      evicted_o    <= !hit_q && evict_q;
      tile_min_x_o <= hit_q ? hmin_x_q : lox_q;
      tile_min_y_o <= hit_q ? hmin_y_q : loy_q;
      last_o       <= sts_o.last_point;
    end
  end

  a_fill_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill && empty_q) |-> !valid_q[empty_idx_q])
    else $error("fill over occupied slot");
  a_no_hit_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> !hit_q)
    else $error("fill on hit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_i.out_load)
    else $error("result overwritten");

endmodule

>>> hdl/stc_ram.sv
// ----------------------------------------------------------------------------
// stc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/spatial_tile_cache_farthest_evict_core.sv
// ----------------------------------------------------------------------------
// spatial_tile_cache_farthest_evict_core
// Fully associative tile cache, farthest-centre eviction, 3x3 neighbour walk.
// ----------------------------------------------------------------------------
// One request (viewer position) yields NeighborSpan^2 results in row-major
// order, one per neighbour point. The block handles one request at a time.
// Per point: form the point, divide in the shared-width serial dividers (a
// start step, one quotient bit a cycle for 26 bits, then a done step; x and
// y side by side), form the bounds, then run the lookup scan through the slot
// RAM's single read port, which stops at the hit slot on a hit and covers all
// CacheSlots on a miss. A miss with the cache full adds an eviction score
// scan over all slots; every miss adds a fill, and each point ends with a
// result step, held while the output stalls.
// The slot RAM needs no clearing pass: per-slot valid flops reset at once.
// tile_width of zero is treated as one. Write tile_width only while idle.
// ----------------------------------------------------------------------------
module spatial_tile_cache_farthest_evict_core #(
  parameter int unsigned CacheSlots   = 16,
  parameter int unsigned NeighborSpan = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stc_pkg::WidthW-1:0]         cfg_data_i,
  // request
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [stc_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [stc_pkg::PosW-1:0]    pos_y_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [stc_pkg::OutIdxW-1:0]        neighbor_o,
  output logic [stc_pkg::OutIdxW-1:0]        slot_o,
  output logic                               hit_o,
  output logic                               evicted_o,
  output logic signed [stc_pkg::CoordW-1:0]  tile_min_x_o,
  output logic signed [stc_pkg::CoordW-1:0]  tile_min_y_o,
  output logic                               last_o
);
  import stc_pkg::*;

  stc_cmd_t          cmd;
  stc_sts_t          sts;
  logic              idle;
  logic [WidthW-1:0] tile_width_q;

  // register always writable; callers must write it only while idle, the block itself does not enforce this
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q <= TileWidthReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tile_width_q <= cfg_data_i;
    end
  end

  stc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_busy_i(out_valid_o && out_stall_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  stc_datapath #(
    .CacheSlots  (CacheSlots),
    .NeighborSpan(NeighborSpan)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pos_x_i,
    .pos_y_i,
    .tile_width_i(tile_width_q),
    .out_valid_o,
    .out_stall_i,
    .neighbor_o,
    .slot_o,
    .hit_o,
    .evicted_o,
    .tile_min_x_o,
    .tile_min_y_o,
    .last_o
  );

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> idle)
    else $error("request taken while busy");
  // after the last result only the first result of a new request may follow
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=>
      (!out_valid_o || (neighbor_o == OutIdxW'(0))))
    else $error("result after last");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_valid_i) |-> (tile_width_q == $past(cfg_data_i)))
    else $error("config write lost");

endmodule
